// ===== design/bwpb_pkg.sv =====
`timescale 1ns / 1ps

package bwpb_pkg;

    localparam int MaxPasses = 4;
    localparam int NumAxes   = 3;

    typedef enum logic [2:0] {
        RegXLow  = 3'd0,
        RegXHigh = 3'd1,
        RegYLow  = 3'd2,
        RegYHigh = 3'd3,
        RegZLow  = 3'd4,
        RegZHigh = 3'd5,
        RegGain  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               hit_wall;
        logic               clamped;
    } out_item_t;

    // Box walls and restitution gain
    typedef struct packed {
        logic [NumAxes-1:0][31:0] lo_wall;
        logic [NumAxes-1:0][31:0] hi_wall;
        logic [16:0]              gain;
    } box_cfg_t;

    // Particle in flight between cells
    typedef struct packed {
        logic [NumAxes-1:0][31:0] pos;
        logic [NumAxes-1:0][31:0] vel;
        logic                     hit;
    } work_t;

endpackage

// ===== design/bwpb_axis.sv =====
`timescale 1ns / 1ps

module bwpb_axis (
    input  logic signed [31:0] pos,
    input  logic signed [31:0] vel,
    input  logic signed [31:0] low_wall,
    input  logic signed [31:0] high_wall,
    input  logic        [16:0] gain,
    output logic signed [31:0] pos_next,
    output logic signed [31:0] vel_next,
    output logic               hit
);

    logic               below;
    logic               above;
    logic               outward;
    logic signed [31:0] wall;
    logic signed [33:0] mirror;
    logic signed [31:0] mirror_sat;
    logic        [31:0] mag;
    logic        [48:0] prod;
    logic        [33:0] rounded;
    logic signed [31:0] scaled;

    always_comb
    begin
        below = pos < low_wall;
        above = !below && (pos > high_wall);
        wall  = below ? low_wall : high_wall;

        // 2*wall - pos, exact in 34 bits, then saturate
        mirror = {wall[31], wall, 1'b0} - {{2{pos[31]}}, pos};
        if (mirror[33:31] == 3'b000 || mirror[33:31] == 3'b111)
        begin
            mirror_sat = mirror[31:0];
        end
        else if (mirror[33])
        begin
            mirror_sat = 32'sh8000_0000;
        end
        else
        begin
            mirror_sat = 32'sh7FFF_FFFF;
        end

        // magnitude times gain, round half away from zero, opposite sign
        mag     = vel[31] ? 32'(-vel) : 32'(vel);
        prod    = 49'(mag) * 49'(gain);
        rounded = 34'((prod + 49'd32768) >> 16);
        if (vel[31])
        begin
            scaled = (rounded > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : rounded[31:0];
        end
        else
        begin
            scaled = (rounded > 34'h0_8000_0000) ? 32'sh8000_0000 : 32'(-rounded[31:0]);
        end

        outward  = (below && vel[31]) || (above && !vel[31] && vel != 32'sd0);
        hit      = below || above;
        pos_next = hit ? mirror_sat : pos;
        vel_next = outward ? scaled : vel;
    end

endmodule

// ===== design/bwpb_pass_cell.sv =====
`timescale 1ns / 1ps

module bwpb_pass_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              valid_in,
    input  bwpb_pkg::work_t   work_in,
    input  bwpb_pkg::box_cfg_t cfg,
    output logic              valid_out,
    output bwpb_pkg::work_t   work_out
);

    logic            valid_reg;
    bwpb_pkg::work_t work_reg;
    bwpb_pkg::work_t work_next;
    logic [bwpb_pkg::NumAxes-1:0] axis_hit;

    for (genvar a = 0; a < bwpb_pkg::NumAxes; a++)
    begin : g_axis
        bwpb_axis u_axis (
            .pos       (work_in.pos[a]),
            .vel       (work_in.vel[a]),
            .low_wall  (cfg.lo_wall[a]),
            .high_wall (cfg.hi_wall[a]),
            .gain      (cfg.gain),
            .pos_next  (work_next.pos[a]),
            .vel_next  (work_next.vel[a]),
            .hit       (axis_hit[a])
        );
    end

    // A pass that reflects nothing leaves the particle as is, so later
    // passes need no early exit.
    assign work_next.hit = work_in.hit || (|axis_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;

endmodule

// ===== design/bwpb_clamp_cell.sv =====
`timescale 1ns / 1ps

module bwpb_clamp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                valid_in,
    input  bwpb_pkg::work_t     work_in,
    input  bwpb_pkg::box_cfg_t  cfg,
    output logic                valid_out,
    output bwpb_pkg::out_item_t item_out
);

    logic                                valid_reg;
    bwpb_pkg::out_item_t                 item_reg;
    bwpb_pkg::out_item_t                 item_next;
    logic [bwpb_pkg::NumAxes-1:0][31:0]  pos_fix;
    logic [bwpb_pkg::NumAxes-1:0]        clamp_hit;

    always_comb
    begin
        for (int a = 0; a < bwpb_pkg::NumAxes; a++)
        begin
            // low wall wins on an inverted box
            if ($signed(work_in.pos[a]) < $signed(cfg.lo_wall[a]))
            begin
                pos_fix[a]   = cfg.lo_wall[a];
                clamp_hit[a] = 1'b1;
            end
            else if ($signed(work_in.pos[a]) > $signed(cfg.hi_wall[a]))
            begin
                pos_fix[a]   = cfg.hi_wall[a];
                clamp_hit[a] = 1'b1;
            end
            else
            begin
                pos_fix[a]   = work_in.pos[a];
                clamp_hit[a] = 1'b0;
            end
        end

        item_next.new_pos_x = pos_fix[0];
        item_next.new_pos_y = pos_fix[1];
        item_next.new_pos_z = pos_fix[2];
        item_next.new_vel_x = work_in.vel[0];
        item_next.new_vel_y = work_in.vel[1];
        item_next.new_vel_z = work_in.vel[2];
        item_next.hit_wall  = work_in.hit;
        item_next.clamped   = |clamp_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

// ===== design/box_wall_particle_bounce.sv =====
`timescale 1ns / 1ps

// Box wall bounce: reflects one particle back into an axis-aligned box,
// scaling outward velocity by the bounce gain, then clamps what is still
// outside. A particle request enters every cycle while no stalled result
// holds the chain; each result passes through every reflection cell in the
// chain and then the clamp cell that holds the result. A stalled result
// freezes the whole chain, so particle_stall follows result_valid and
// result_stall. Wall and gain writes take effect at the next clock and
// must only be made while no particle is in flight.
module box_wall_particle_bounce (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                particle_valid,
    output logic                particle_stall,
    input  bwpb_pkg::in_item_t  particle,
    output logic                result_valid,
    input  logic                result_stall,
    output bwpb_pkg::out_item_t result,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [31:0]         wr_data
);

    bwpb_pkg::box_cfg_t cfg_reg;
    bwpb_pkg::box_cfg_t cfg_next;
    logic               advance;

    bwpb_pkg::work_t chain_work  [bwpb_pkg::MaxPasses+1];
    logic            chain_valid [bwpb_pkg::MaxPasses+1];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (bwpb_pkg::reg_index_t'(wr_index))
                bwpb_pkg::RegXLow:  cfg_next.lo_wall[0] = wr_data;
                bwpb_pkg::RegXHigh: cfg_next.hi_wall[0] = wr_data;
                bwpb_pkg::RegYLow:  cfg_next.lo_wall[1] = wr_data;
                bwpb_pkg::RegYHigh: cfg_next.hi_wall[1] = wr_data;
                bwpb_pkg::RegZLow:  cfg_next.lo_wall[2] = wr_data;
                bwpb_pkg::RegZHigh: cfg_next.hi_wall[2] = wr_data;
                bwpb_pkg::RegGain:  cfg_next.gain       = wr_data[16:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < bwpb_pkg::NumAxes; a++)
            begin
                cfg_reg.lo_wall[a] <= -32'sd1966080;
                cfg_reg.hi_wall[a] <= 32'sd1966080;
            end
            cfg_reg.gain <= 17'd13107;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // hold every cell while the result waits
    assign advance        = !(result_valid && result_stall);
    assign particle_stall = !advance;

    assign chain_valid[0]      = particle_valid;
    assign chain_work[0].pos[0] = particle.pos_x;
    assign chain_work[0].pos[1] = particle.pos_y;
    assign chain_work[0].pos[2] = particle.pos_z;
    assign chain_work[0].vel[0] = particle.vel_x;
    assign chain_work[0].vel[1] = particle.vel_y;
    assign chain_work[0].vel[2] = particle.vel_z;
    assign chain_work[0].hit    = 1'b0;

    for (genvar c = 0; c < bwpb_pkg::MaxPasses; c++)
    begin : g_cell
        bwpb_pass_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (chain_valid[c]),
            .work_in   (chain_work[c]),
            .cfg       (cfg_reg),
            .valid_out (chain_valid[c+1]),
            .work_out  (chain_work[c+1])
        );
    end

    bwpb_clamp_cell u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (chain_valid[bwpb_pkg::MaxPasses]),
        .work_in   (chain_work[bwpb_pkg::MaxPasses]),
        .cfg       (cfg_reg),
        .valid_out (result_valid),
        .item_out  (result)
    );

    // result position lies between the walls on every axis that is not inverted
    logic [bwpb_pkg::NumAxes-1:0][31:0] res_pos;
    logic                               box_ok;

    assign res_pos[0] = result.new_pos_x;
    assign res_pos[1] = result.new_pos_y;
    assign res_pos[2] = result.new_pos_z;

    always_comb
    begin
        box_ok = 1'b1;
        for (int a = 0; a < bwpb_pkg::NumAxes; a++)
        begin
            if ($signed(cfg_reg.lo_wall[a]) <= $signed(cfg_reg.hi_wall[a]))
            begin
                if ($signed(res_pos[a]) < $signed(cfg_reg.lo_wall[a]) ||
                    $signed(res_pos[a]) > $signed(cfg_reg.hi_wall[a]))
                begin
                    box_ok = 1'b0;
                end
            end
        end
    end

    a_inside_box: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> box_ok)
        else $error("result position outside box");

    a_clamp_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.clamped) |-> result.hit_wall)
        else $error("clamp without reflection");

    a_first_cell_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (particle_valid && !particle_stall) |=> chain_valid[1])
        else $error("accepted particle missing from first cell");

endmodule
